@@ hw/rtl/tlws_pkg.sv @@
// Shared types, constants and helpers for the text line and word statistics block.
`timescale 1ns / 1ps

package tlws_pkg;

  localparam int HIST_BINS   = 256;
  localparam int BIN_W       = $clog2(HIST_BINS);
  localparam int COUNT_WIDTH = 32;
  localparam int LEN_WIDTH   = 16;
  localparam int KIND_W      = 2;
  localparam int OUT_BITS    = 3 * COUNT_WIDTH + 4 * LEN_WIDTH + COUNT_WIDTH + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_TDATA_W  = 8;

  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EOL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [BIN_W-1:0] SPACE_BYTE = 8'h20;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LEN_WIDTH-1:0]   len_t;

  // Running scalar statistics
  typedef struct packed {
    count_t lines;
    count_t chars;
    count_t words;
    len_t   line_len;
    len_t   word_len;
    logic   inside_word;
    logic   any_word_done;
    len_t   max_line;
    len_t   min_line;
    len_t   max_word;
    len_t   min_word;
  } stats_t;

  function automatic count_t count_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

  function automatic len_t len_inc(input len_t v);
    return (v == '1) ? v : len_t'(v + 1'b1);
  endfunction

endpackage

@@ hw/rtl/tlws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/text_line_word_statistics.sv @@
// Top level: byte histogram with running line, character and word statistics.
//
//   channel | dir | tdata                  | tuser          | per item
//   s_*     | in  | [7:0] byte_value        | [1:0] kind     | one byte / end of line / bin read
//   m_*     | out | stats + bin_value      | -              | one result per input item
//
// One item per cycle sustained while m_tready is high. Stage 1 waits for the histogram RAM read issued
// at accept; the updated bin is written back as the item moves to the output
// register, and a read that coincides with that write takes the forwarded value.
// m_tvalid rises once an accepted item has passed through stage 1 into the output register.
// rst (synchronous) clears all counters and the per-bin valid bits; unwritten bins read zero.
// s_tready drops only when stage 1 and the output register are full and m_tready is low.
`timescale 1ns / 1ps

module text_line_word_statistics (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tlws_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] byte_value
  input  logic [tlws_pkg::KIND_W-1:0]       s_tuser,  // [1:0] kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] line_total, [63:32] char_total, [95:64] word_total,
  // [111:96] longest_line, [127:112] shortest_line, [143:128] longest_word,
  // [159:144] shortest_word, [191:160] bin_value, [192] no_lines_yet, rest zero
  output logic [tlws_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  import tlws_pkg::*;

  logic [KIND_W-1:0] kind;
  logic [BIN_W-1:0]  byte_value;
  logic              accept;
  logic              advance;

  stats_t st;
  stats_t st_next;
  logic   close_word;

  // stage 1
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [BIN_W-1:0]  s1_addr;
  stats_t            s1_st;
  logic              s1_vld;
  logic              s1_fwd_hit;
  count_t            s1_fwd_data;
  count_t            ram_rdata;
  count_t            s1_bin_old;
  count_t            s1_bin_new;
  logic              s1_write;

  logic [HIST_BINS-1:0] bin_valid;

  assign kind       = s_tuser;
  assign byte_value = s_tdata[BIN_W-1:0];

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // scalar statistics update for the incoming item
  always_comb begin
    st_next    = st;
    close_word = st.inside_word &&
                 (((kind == KIND_TEXT) && (byte_value == SPACE_BYTE)) || (kind == KIND_EOL));
    if (close_word) begin
      if (st.word_len > st.max_word) begin
        st_next.max_word = st.word_len;
      end
      if (!st.any_word_done || (st.word_len < st.min_word)) begin
        st_next.min_word = st.word_len;
      end
      st_next.any_word_done = 1'b1;
      st_next.inside_word   = 1'b0;
      st_next.word_len      = '0;
    end
    if (kind == KIND_TEXT) begin
      st_next.chars    = count_inc(st.chars);
      st_next.line_len = len_inc(st.line_len);
      if (byte_value != SPACE_BYTE) begin
        if (!st.inside_word) begin
          st_next.words       = count_inc(st.words);
          st_next.inside_word = 1'b1;
          st_next.word_len    = len_t'(1);
        end else begin
          st_next.word_len = len_inc(st.word_len);
        end
      end
    end else if (kind == KIND_EOL) begin
      if (st.lines == '0) begin
        st_next.max_line = st.line_len;
        st_next.min_line = st.line_len;
      end else begin
        if (st.line_len > st.max_line) begin
          st_next.max_line = st.line_len;
        end
        if (st.line_len < st.min_line) begin
          st_next.min_line = st.line_len;
        end
      end
      st_next.lines    = count_inc(st.lines);
      st_next.line_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // histogram
  tlws_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HIST_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr),
    .wdata (s1_bin_new),
    .re    (accept),
    .raddr (byte_value),
    .rdata (ram_rdata)
  );

  assign s1_write   = s1_valid && advance && (s1_kind == KIND_TEXT);
  assign s1_bin_old = s1_fwd_hit ? s1_fwd_data : (s1_vld ? ram_rdata : '0);
  assign s1_bin_new = (s1_kind == KIND_TEXT) ? count_inc(s1_bin_old) : s1_bin_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (s1_write) begin
      bin_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // the write leaving stage 1 on this edge is not yet visible to the RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= kind;
      s1_addr     <= byte_value;
      s1_st       <= st_next;
      s1_vld      <= bin_valid[byte_value];
      s1_fwd_hit  <= s1_write && (s1_addr == byte_value);
      s1_fwd_data <= s1_bin_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= OUT_TDATA_W'({(s1_st.lines == '0), s1_bin_new,
                               s1_st.min_word, s1_st.max_word,
                               s1_st.min_line, s1_st.max_line,
                               s1_st.words, s1_st.chars, s1_st.lines});
    end
  end

  localparam int O_LINES  = 0;
  localparam int O_MAXL   = 3 * COUNT_WIDTH;
  localparam int O_MINL   = O_MAXL + LEN_WIDTH;
  localparam int O_MAXW   = O_MINL + LEN_WIDTH;
  localparam int O_MINW   = O_MAXW + LEN_WIDTH;
  localparam int O_NOLINE = O_MINW + LEN_WIDTH + COUNT_WIDTH;

  a_no_lines_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[O_NOLINE] == (m_tdata[O_LINES +: COUNT_WIDTH] == '0)))
    else $error("no_lines_yet disagrees with line_total");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[O_MINL +: LEN_WIDTH] <= m_tdata[O_MAXL +: LEN_WIDTH]))
    else $error("shortest_line above longest_line");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[O_MINW +: LEN_WIDTH] <= m_tdata[O_MAXW +: LEN_WIDTH]))
    else $error("shortest_word above longest_word");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule
